>>> sv/m3a_pkg.sv
// Shared types, constants and the determinant schedule of the 3x3 matrix unit.
`timescale 1ns / 1ps

package m3a_pkg;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    // Element format
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int EW         = (ELEM_WIDTH < FIELD_W) ? ELEM_WIDTH : FIELD_W;
    localparam int WORD_W     = 2 * EW;

    // Matrix geometry
    localparam int NUM_ELEM = 9;
    localparam int ADDR_W   = $clog2(NUM_ELEM);
    localparam int POS_W    = 4;
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(2);
    localparam logic [POS_W-1:0] POS_DET  = '0;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_ELEM - 1);

    // Datapath widths: a 2x2 minor is MW bits wide and is fed to the
    // multiplier in two halves split at SPLIT (SPLIT >= FRAC_BITS keeps the
    // upper half free of any rounding).
    localparam int MW    = 2 * EW - FRAC_BITS + 1;
    localparam int SPLIT = imax(FRAC_BITS, MW / 2);
    localparam int MWX   = imax(MW, SPLIT + 1);
    localparam int MH_W  = MWX - SPLIT;
    localparam int YW    = imax(EW, imax(MH_W, SPLIT + 1));
    localparam int PW    = EW + YW;
    localparam int ACC_W = imax(PW + SPLIT - FRAC_BITS, EW + 1) + 2;

    // Saturation rails
    localparam logic [EW-1:0] EW_MAX = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] EW_MIN = {1'b1, {(EW - 1){1'b0}}};
    localparam logic [FIELD_W-1:0] SAT_HI = FIELD_W'($signed(EW_MAX));
    localparam logic [FIELD_W-1:0] SAT_LO = FIELD_W'($signed(EW_MIN));

    // Determinant schedule length
    localparam int DET_STEPS = 15;
    localparam int DSTEP_W   = $clog2(DET_STEPS);
    localparam logic [DSTEP_W-1:0] DSTEP_LAST = DSTEP_W'(DET_STEPS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_SCALE,
        CMD_PROD,
        CMD_DET
    } t_cmd;

    typedef enum logic [1:0] {
        SEQ_LOAD,
        SEQ_ELEM,
        SEQ_DET
    } t_seq_state;

    typedef enum logic [1:0] {
        MODE_MUL,
        MODE_ADD,
        MODE_SUB
    } t_mode;

    typedef enum logic [2:0] {
        Y_B,
        Y_A,
        Y_SCALAR,
        Y_MHI,
        Y_MLO
    } t_ysel;

    // One pipeline operation
    typedef struct packed {
        logic             valid;
        t_mode            mode;
        t_ysel            ysel;
        logic             neg;
        logic             minor;
        logic             first;
        logic             emit;
        logic             last;
        logic [POS_W-1:0] pos;
    } t_op;

    typedef struct packed {
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        t_op               op;
    } t_det_entry;

    localparam t_op OP_IDLE = '{valid: 1'b0, mode: MODE_MUL, ysel: Y_B, neg: 1'b0,
                                minor: 1'b0, first: 1'b0, emit: 1'b0, last: 1'b0,
                                pos: '0};

    function automatic t_det_entry det_mk(input int a0, input int a1, input t_ysel ysel,
                                          input logic minor, input logic neg,
                                          input logic first, input logic emit);
        t_det_entry e;
        e.addr0    = ADDR_W'(a0);
        e.addr1    = ADDR_W'(a1);
        e.op       = OP_IDLE;
        e.op.valid = 1'b1;
        e.op.ysel  = ysel;
        e.op.minor = minor;
        e.op.neg   = neg;
        e.op.first = first;
        e.op.emit  = emit;
        e.op.last  = emit;
        e.op.pos   = POS_DET;
        return e;
    endfunction

    // Cofactor expansion along row 0. Each minor builds in the minor
    // accumulator, then one idle slot lets it settle before use.
    function automatic t_det_entry det_entry(input logic [DSTEP_W-1:0] step);
        t_det_entry e;
        e = '{addr0: '0, addr1: '0, op: OP_IDLE};
        unique case (step)
            4'd0:    e = det_mk(4, 8, Y_A,   1'b1, 1'b0, 1'b1, 1'b0);
            4'd1:    e = det_mk(5, 7, Y_A,   1'b1, 1'b1, 1'b0, 1'b0);
            4'd3:    e = det_mk(0, 0, Y_MHI, 1'b0, 1'b0, 1'b1, 1'b0);
            4'd4:    e = det_mk(0, 0, Y_MLO, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd5:    e = det_mk(3, 8, Y_A,   1'b1, 1'b0, 1'b1, 1'b0);
            4'd6:    e = det_mk(5, 6, Y_A,   1'b1, 1'b1, 1'b0, 1'b0);
            4'd8:    e = det_mk(1, 0, Y_MHI, 1'b0, 1'b1, 1'b0, 1'b0);
            4'd9:    e = det_mk(1, 0, Y_MLO, 1'b0, 1'b1, 1'b0, 1'b0);
            4'd10:   e = det_mk(3, 7, Y_A,   1'b1, 1'b0, 1'b1, 1'b0);
            4'd11:   e = det_mk(4, 6, Y_A,   1'b1, 1'b1, 1'b0, 1'b0);
            4'd13:   e = det_mk(2, 0, Y_MHI, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd14:   e = det_mk(2, 0, Y_MLO, 1'b0, 1'b0, 1'b0, 1'b1);
            default: e = '{addr0: '0, addr1: '0, op: OP_IDLE};
        endcase
        return e;
    endfunction

    function automatic logic [ADDR_W-1:0] mul3(input logic [IDX_W-1:0] x);
        return ADDR_W'({x, 1'b0}) + ADDR_W'(x);
    endfunction

endpackage

>>> sv/matrix3x3_arith_unit.sv
// Words one to eight only load; after the ninth word is taken each result passes the store
//   read registers, the product register and the output register before it is valid.
// Throughput: one word per cycle while loading, then one operation per cycle on the shared
//   multiplier: 9, 27 or 15 per run; words and the pipeline both hold while a finished result
//   meets a blocked output.
// Reset: synchronous, active low; clears sequencer, counters and valid bits, not the store.
`timescale 1ns / 1ps

module matrix3x3_arith_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [m3a_pkg::CMD_W-1:0]    i_cmd,
    input  logic [m3a_pkg::FIELD_W-1:0]  i_a_value,
    input  logic [m3a_pkg::FIELD_W-1:0]  i_b_value,
    input  logic [m3a_pkg::FIELD_W-1:0]  i_scalar,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [m3a_pkg::FIELD_W-1:0]  o_value,
    output logic [m3a_pkg::POS_W-1:0]    o_position,
    output logic                         o_saturated,
    output logic                         o_last
);
    import m3a_pkg::*;

    // Sequencer to pipeline
    t_op               w_op;
    logic              w_advance;
    logic              w_start;
    // Store ports
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic [ADDR_W-1:0] w_rd_addr0;
    logic [ADDR_W-1:0] w_rd_addr1;
    logic [WORD_W-1:0] w_rd_data0;
    logic [WORD_W-1:0] w_rd_data1;

    // Each accepted word drops its A and B elements into one store entry,
    // addressed by the load counter; elements are held at EW bits.
    assign w_wr_data = {i_a_value[EW-1:0], i_b_value[EW-1:0]};

    // The sequencer counts loads; on the ninth word it latches the command and
    // steps through the operation list for that command, one per cycle unless the pipeline holds. It
    // takes no word while a run is being issued or while the pipeline holds.
    m3a_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_advance  (w_advance),
        .o_in_ready (o_in_ready),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_start    (w_start),
        .o_rd_addr0 (w_rd_addr0),
        .o_rd_addr1 (w_rd_addr1),
        .o_op       (w_op)
    );

    // Port 0 always supplies the A operand; port 1 supplies the B element, or a
    // second A element for the determinant minors. The last load and the first
    // read of a run fall on different edges, so no forwarding is needed.
    m3a_store u_store (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_en    (w_advance),
        .i_rd_addr0 (w_rd_addr0),
        .i_rd_addr1 (w_rd_addr1),
        .o_rd_data0 (w_rd_data0),
        .o_rd_data1 (w_rd_data1)
    );

    // Read, multiply, accumulate. The whole pipeline holds only when a
    // finished element meets a full output register that is not being taken.
    // Determinant minors build in a second accumulator and feed back into the
    // multiplier as an upper and a lower half.
    m3a_mac u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_rd_data0    (w_rd_data0),
        .i_rd_data1    (w_rd_data1),
        .i_scalar_load (w_start),
        .i_scalar      (i_scalar),
        .i_out_ready   (i_out_ready),
        .o_advance     (w_advance),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_position    (o_position),
        .o_saturated   (o_saturated),
        .o_last        (o_last)
    );

`ifndef NO_ASSERTIONS
    // A stall only ever comes from a blocked output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |-> (o_out_valid && !i_out_ready))
        else $error("pipeline held without a blocked output word");

    // No operation is issued while words are being loaded.
    a_issue_vs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.valid |-> !o_in_ready)
        else $error("operation issued while accepting words");

    // A clipped value sits on one of the two rails.
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_value == SAT_HI || o_value == SAT_LO))
        else $error("saturated word off the rails");

    // The final word of a run is either element eight or the determinant.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_position == POS_LAST || o_position == POS_DET))
        else $error("last flag on an unexpected position");
`endif

endmodule

>>> sv/m3a_store.sv
// Element store: nine {A, B} words, one write port, two registered read ports.
`timescale 1ns / 1ps

module m3a_store (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [m3a_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [m3a_pkg::WORD_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [m3a_pkg::ADDR_W-1:0]  i_rd_addr0,
    input  logic [m3a_pkg::ADDR_W-1:0]  i_rd_addr1,
    output logic [m3a_pkg::WORD_W-1:0]  o_rd_data0,
    output logic [m3a_pkg::WORD_W-1:0]  o_rd_data1
);
    import m3a_pkg::*;

    logic [WORD_W-1:0] r_mem [NUM_ELEM];
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0 <= r_mem[i_rd_addr0];
            r_rd1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

>>> sv/m3a_seq.sv
// Sequencer: load counting and issue of read-multiply-accumulate operations.
`timescale 1ns / 1ps

module m3a_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [m3a_pkg::CMD_W-1:0]   i_cmd,
    input  logic                        i_advance,
    output logic                        o_in_ready,
    output logic                        o_wr_en,
    output logic [m3a_pkg::ADDR_W-1:0]  o_wr_addr,
    output logic                        o_start,
    output logic [m3a_pkg::ADDR_W-1:0]  o_rd_addr0,
    output logic [m3a_pkg::ADDR_W-1:0]  o_rd_addr1,
    output m3a_pkg::t_op                o_op
);
    import m3a_pkg::*;

    t_seq_state         r_state;
    t_seq_state         n_state;
    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_load_cnt;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic [IDX_W-1:0]   r_k;
    logic [DSTEP_W-1:0] r_step;
    logic               w_accept;
    logic               w_ninth;
    logic               w_k_last;
    logic [ADDR_W-1:0]  w_elem;
    t_det_entry         w_det;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_ninth  = (r_load_cnt == ADDR_W'(NUM_ELEM - 1));
    assign w_k_last = (r_cmd == CMD_PROD) ? (r_k == IDX_LAST) : 1'b1;
    assign w_elem   = mul3(r_row) + ADDR_W'(r_col);
    assign w_det    = det_entry(r_step);

    assign o_wr_en   = w_accept;
    assign o_wr_addr = r_load_cnt;
    assign o_start   = w_accept && w_ninth;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_LOAD: begin
                if (w_accept && w_ninth) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_ADD, CMD_SUB, CMD_SCALE, CMD_PROD: n_state = SEQ_ELEM;
                        CMD_DET: n_state = SEQ_DET;
                        default: n_state = SEQ_LOAD;
                    endcase
                end
            end
            SEQ_ELEM: begin
                if (i_advance && w_k_last && (r_row == IDX_LAST) && (r_col == IDX_LAST)) begin
                    n_state = SEQ_LOAD;
                end
            end
            SEQ_DET: begin
                if (i_advance && (r_step == DSTEP_LAST)) begin
                    n_state = SEQ_LOAD;
                end
            end
            default: n_state = SEQ_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_rd_addr0 = w_elem;
        o_rd_addr1 = w_elem;
        o_op       = OP_IDLE;
        unique case (r_state)
            SEQ_LOAD: begin
                // take no word while the pipeline holds, so a waiting
                // operation keeps the scalar it was issued with
                o_in_ready = i_advance;
            end
            SEQ_ELEM: begin
                if (r_cmd == CMD_PROD) begin
                    o_rd_addr0 = mul3(r_row) + ADDR_W'(r_k);
                    o_rd_addr1 = mul3(r_k) + ADDR_W'(r_col);
                end
                o_op.valid = 1'b1;
                unique case (r_cmd)
                    CMD_ADD: o_op.mode = MODE_ADD;
                    CMD_SUB: o_op.mode = MODE_SUB;
                    default: o_op.mode = MODE_MUL;
                endcase
                o_op.ysel  = (r_cmd == CMD_SCALE) ? Y_SCALAR : Y_B;
                o_op.first = (r_k == '0);
                o_op.emit  = w_k_last;
                o_op.last  = w_k_last && (r_row == IDX_LAST) && (r_col == IDX_LAST);
                o_op.pos   = POS_W'(w_elem);
            end
            SEQ_DET: begin
                o_rd_addr0 = w_det.addr0;
                o_rd_addr1 = w_det.addr1;
                o_op       = w_det.op;
            end
            default: o_op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SEQ_LOAD;
            r_cmd      <= CMD_ADD;
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
            r_step     <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (w_ninth) begin
                    r_load_cnt <= '0;
                    r_cmd      <= t_cmd'(i_cmd);
                    r_row      <= '0;
                    r_col      <= '0;
                    r_k        <= '0;
                    r_step     <= '0;
                end else begin
                    r_load_cnt <= r_load_cnt + 1'b1;
                end
            end
            if (i_advance && (r_state == SEQ_ELEM)) begin
                if (w_k_last) begin
                    r_k <= '0;
                    if (r_col == IDX_LAST) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (i_advance && (r_state == SEQ_DET)) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

endmodule

>>> sv/m3a_mac.sv
// Shared multiplier, accumulators, saturation and output register.
`timescale 1ns / 1ps

module m3a_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  m3a_pkg::t_op                 i_op,
    input  logic [m3a_pkg::WORD_W-1:0]   i_rd_data0,
    input  logic [m3a_pkg::WORD_W-1:0]   i_rd_data1,
    input  logic                         i_scalar_load,
    input  logic [m3a_pkg::FIELD_W-1:0]  i_scalar,
    input  logic                         i_out_ready,
    output logic                         o_advance,
    output logic                         o_out_valid,
    output logic [m3a_pkg::FIELD_W-1:0]  o_value,
    output logic [m3a_pkg::POS_W-1:0]    o_position,
    output logic                         o_saturated,
    output logic                         o_last
);
    import m3a_pkg::*;

    t_op                      r_s1_op;
    t_op                      r_s2_op;
    logic [EW-1:0]            r_scalar;
    logic signed [PW-1:0]     r_prod;
    logic signed [ACC_W-1:0]  r_acc0;
    logic signed [MWX-1:0]    r_acc1;
    logic                     r_out_valid;
    logic [FIELD_W-1:0]       r_value;
    logic [POS_W-1:0]         r_position;
    logic                     r_saturated;
    logic                     r_last;

    logic signed [EW-1:0]     w_x;
    logic signed [EW-1:0]     w_a1;
    logic signed [EW-1:0]     w_b1;
    logic signed [YW-1:0]     w_y;
    logic signed [PW-1:0]     w_mul;
    logic signed [PW-1:0]     w_s2_next;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  w_acc_next;
    logic [ACC_W-EW:0]        w_hi;
    logic                     w_fits;
    logic [EW-1:0]            w_clip;
    logic                     w_emit;

    assign w_emit    = r_s2_op.valid && r_s2_op.emit;
    assign o_advance = !(w_emit && r_out_valid && !i_out_ready);

    // operand selection and the one multiplier
    assign w_x  = $signed(i_rd_data0[WORD_W-1:EW]);
    assign w_a1 = $signed(i_rd_data1[WORD_W-1:EW]);
    assign w_b1 = $signed(i_rd_data1[EW-1:0]);

    always_comb begin
        unique case (r_s1_op.ysel)
            Y_B:      w_y = YW'(w_b1);
            Y_A:      w_y = YW'(w_a1);
            Y_SCALAR: w_y = YW'($signed(r_scalar));
            Y_MHI:    w_y = YW'($signed(r_acc1[MWX-1:SPLIT]));
            Y_MLO:    w_y = YW'({1'b0, r_acc1[SPLIT-1:0]});
            default:  w_y = YW'(w_b1);
        endcase
    end

    assign w_mul = w_x * w_y;

    always_comb begin
        unique case (r_s1_op.mode)
            MODE_ADD: w_s2_next = PW'(w_x) + PW'(w_b1);
            MODE_SUB: w_s2_next = PW'(w_x) - PW'(w_b1);
            default:  w_s2_next = w_mul;
        endcase
    end

    // rescale the product and accumulate
    assign w_prod_ext = ACC_W'(r_prod);

    always_comb begin
        priority if (r_s2_op.mode != MODE_MUL) begin
            w_term = w_prod_ext;
        end else if (r_s2_op.ysel == Y_MHI) begin
            w_term = w_prod_ext <<< (SPLIT - FRAC_BITS);
        end else begin
            w_term = w_prod_ext >>> FRAC_BITS;
        end
        priority if (r_s2_op.first) begin
            w_base = '0;
        end else if (r_s2_op.minor) begin
            w_base = ACC_W'(r_acc1);
        end else begin
            w_base = r_acc0;
        end
        w_acc_next = r_s2_op.neg ? (w_base - w_term) : (w_base + w_term);
    end

    // clip to the element range
    assign w_hi   = w_acc_next[ACC_W-1:EW-1];
    assign w_fits = (&w_hi) || !(|w_hi);
    assign w_clip = w_fits ? w_acc_next[EW-1:0] : (w_acc_next[ACC_W-1] ? EW_MIN : EW_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op     <= OP_IDLE;
            r_s2_op     <= OP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_s1_op <= i_op;
                r_s2_op <= r_s1_op;
            end
            if (o_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scalar_load) begin
            r_scalar <= i_scalar[EW-1:0];
        end
        if (o_advance) begin
            r_prod <= w_s2_next;
        end
        if (o_advance && r_s2_op.valid) begin
            if (r_s2_op.minor) begin
                r_acc1 <= MWX'(w_acc_next);
            end else begin
                r_acc0 <= w_acc_next;
            end
        end
        if (o_advance && w_emit) begin
            r_value     <= FIELD_W'($signed(w_clip));
            r_position  <= r_s2_op.pos;
            r_saturated <= !w_fits;
            r_last      <= r_s2_op.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_position  = r_position;
    assign o_saturated = r_saturated;
    assign o_last      = r_last;

endmodule
